FILE: rtl/grid_explorer_with_backtrack_core_defines.svh
// Assertion helpers for the grid explorer; clk and arst_n come from the including module.
`ifndef GRID_EXPLORER_WITH_BACKTRACK_CORE_DEFINES_SVH
`define GRID_EXPLORER_WITH_BACKTRACK_CORE_DEFINES_SVH

// same-cycle implication
`define GEXP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define GEXP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/gexp_pkg.sv
package gexp_pkg;

	localparam int GRID_SIDE_BITS = 6;
	localparam int STACK_DEPTH    = 4096;
	localparam int CHARGE_RESET   = 20;

	localparam int CELL_W  = 2 * GRID_SIDE_BITS;
	localparam int SP_W    = $clog2(STACK_DEPTH);
	localparam int CNT_W   = $clog2(STACK_DEPTH + 1);
	localparam int BATT_W  = 16;
	localparam int CMP_W   = (BATT_W > CNT_W) ? BATT_W : CNT_W;
	localparam int OFF_W   = 6;
	localparam int CELLS   = 1 << CELL_W;

	typedef logic        [CELL_W-1:0]         cell_t;
	typedef logic        [SP_W-1:0]           sp_t;
	typedef logic        [CNT_W-1:0]          cnt_t;
	typedef logic        [CMP_W-1:0]          cmp_t;
	typedef logic signed [GRID_SIDE_BITS-1:0] pos_t;
	typedef logic signed [OFF_W-1:0]          off_t;

	localparam pos_t POS_MAX = pos_t'((1 << (GRID_SIDE_BITS - 1)) - 1);
	localparam pos_t POS_MIN = pos_t'(-(1 << (GRID_SIDE_BITS - 1)));

	typedef enum logic [1:0] {
		DIR_N = 2'd0,
		DIR_E = 2'd1,
		DIR_S = 2'd2,
		DIR_W = 2'd3
	} dir_t;

	typedef enum logic [2:0] {
		MV_STAY   = 3'd0,
		MV_NORTH  = 3'd1,
		MV_EAST   = 3'd2,
		MV_SOUTH  = 3'd3,
		MV_WEST   = 3'd4,
		MV_FINISH = 3'd5
	} move_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DECIDE,
		ST_PROBE,
		ST_POP
	} state_t;

	function automatic dir_t opp_dir(dir_t d);
		unique case (d)
			DIR_N: opp_dir = DIR_S;
			DIR_E: opp_dir = DIR_W;
			DIR_S: opp_dir = DIR_N;
			DIR_W: opp_dir = DIR_E;
		endcase
	endfunction

	function automatic dir_t next_dir(dir_t d);
		unique case (d)
			DIR_N: next_dir = DIR_E;
			DIR_E: next_dir = DIR_S;
			DIR_S: next_dir = DIR_W;
			DIR_W: next_dir = DIR_N;
		endcase
	endfunction

	function automatic move_t move_of(dir_t d);
		unique case (d)
			DIR_N: move_of = MV_NORTH;
			DIR_E: move_of = MV_EAST;
			DIR_S: move_of = MV_SOUTH;
			DIR_W: move_of = MV_WEST;
		endcase
	endfunction

	function automatic pos_t step_x(pos_t x, dir_t d);
		unique case (d)
			DIR_E:        step_x = x + pos_t'(1);
			DIR_W:        step_x = x - pos_t'(1);
			DIR_N, DIR_S: step_x = x;
		endcase
	endfunction

	function automatic pos_t step_y(pos_t y, dir_t d);
		unique case (d)
			DIR_S:        step_y = y + pos_t'(1);
			DIR_N:        step_y = y - pos_t'(1);
			DIR_E, DIR_W: step_y = y;
		endcase
	endfunction

	// true when the step stays on the grid
	function automatic logic on_grid(pos_t x, pos_t y, dir_t d);
		unique case (d)
			DIR_N: on_grid = (y != POS_MIN);
			DIR_E: on_grid = (x != POS_MAX);
			DIR_S: on_grid = (y != POS_MAX);
			DIR_W: on_grid = (x != POS_MIN);
		endcase
	endfunction

	function automatic cell_t cell_of(pos_t x, pos_t y);
		cell_of = {x, y};
	endfunction

endpackage

FILE: rtl/gexp_ram.sv
module gexp_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		// read data holds until the next read
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/grid_explorer_with_backtrack_core.sv
// Channel   | Dir | Beat contents
// s_*       | in  | tdata: dirt_level[3:0], battery_steps[19:4], wall_bits[23:20]
// m_*       | out | tdata: move_code[2:0], offset_x[8:3], offset_y[14:9]; tuser: charging_now
// cfg_*     | in  | charge_ticks, written on any cycle with cfg_we high
//
// From accept to the next accept an item passes through idle to take the beat, decide to
// mark the cell, then probe with one visited-map read per neighbor tried (up to four) and
// pop for the move stack. The single read port of the visited map sets the probe rate.
// After reset, and after each finished charge, the visited map is cleared one cell a cycle,
// all 4096 cells, with s_tready low.
// A finished result waits in the decide, probe or pop state while the output register is full.
`include "grid_explorer_with_backtrack_core_defines.svh"

module grid_explorer_with_backtrack_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // dirt_level, battery_steps, wall_bits
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // move_code, offset_x, offset_y, zero pad
	output logic        m_tuser,   // charging_now
	input  logic        cfg_we,
	input  logic [7:0]  cfg_data
);

	gexp_pkg::state_t state_q, state_d;

	gexp_pkg::cnt_t  cnt_q, cnt_d;
	gexp_pkg::pos_t  pos_x_q, pos_x_d, pos_y_q, pos_y_d;
	logic            chg_flag_q, chg_flag_d;
	logic [7:0]      chg_left_q, chg_left_d;
	logic [7:0]      chg_ticks_q;
	logic            chg_path_q, chg_path_d;
	gexp_pkg::dir_t  probe_d_q, probe_d_d;
	gexp_pkg::cell_t clr_addr_q, clr_addr_d;

	logic [3:0]  dirt_q, walls_q;
	logic [15:0] batt_q;

	logic        m_tvalid_q;
	logic [15:0] m_tdata_q;
	logic        m_tuser_q;

	logic            vis_we, vis_wdata, vis_re, vis_rdata;
	gexp_pkg::cell_t vis_waddr, vis_raddr;
	logic            stk_we, stk_re;
	gexp_pkg::sp_t   stk_waddr, stk_raddr;
	logic [1:0]      stk_wdata, stk_rdata;

	logic             fin;
	gexp_pkg::move_t  res_code;
	logic             res_chg;
	logic             out_free;

	assign out_free = !m_tvalid_q || m_tready;

	gexp_ram #(.WIDTH(1), .DEPTH(gexp_pkg::CELLS)) u_visited (
		.clk   (clk),
		.we    (vis_we),
		.waddr (vis_waddr),
		.wdata (vis_wdata),
		.re    (vis_re),
		.raddr (vis_raddr),
		.rdata (vis_rdata)
	);

	gexp_ram #(.WIDTH(2), .DEPTH(gexp_pkg::STACK_DEPTH)) u_stack (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.re    (stk_re),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gexp_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		logic           chg_go;
		logic [7:0]     chl;
		logic [7:0]     chl_dec;
		logic           ok;
		gexp_pkg::dir_t pd;

		state_d    = state_q;
		cnt_d      = cnt_q;
		pos_x_d    = pos_x_q;
		pos_y_d    = pos_y_q;
		chg_flag_d = chg_flag_q;
		chg_left_d = chg_left_q;
		chg_path_d = chg_path_q;
		probe_d_d  = probe_d_q;
		clr_addr_d = clr_addr_q;

		s_tready  = 1'b0;
		vis_we    = 1'b0;
		vis_waddr = gexp_pkg::cell_of(pos_x_q, pos_y_q);
		vis_wdata = 1'b0;
		vis_re    = 1'b0;
		vis_raddr = gexp_pkg::cell_of(gexp_pkg::step_x(pos_x_q, probe_d_q),
			gexp_pkg::step_y(pos_y_q, probe_d_q));
		stk_we    = 1'b0;
		stk_waddr = cnt_q[gexp_pkg::SP_W-1:0];
		stk_wdata = probe_d_q;
		stk_re    = 1'b0;
		stk_raddr = gexp_pkg::sp_t'(cnt_q - gexp_pkg::cnt_t'(1));

		fin      = 1'b0;
		res_code = gexp_pkg::MV_STAY;
		res_chg  = 1'b0;

		chg_go  = chg_flag_q ||
			(gexp_pkg::cmp_t'(batt_q) <= gexp_pkg::cmp_t'(cnt_q));
		chl     = chg_flag_q ? chg_left_q : chg_ticks_q;
		chl_dec = chl - 8'd1;
		pd      = probe_d_q;
		ok      = !walls_q[pd] && gexp_pkg::on_grid(pos_x_q, pos_y_q, pd) &&
			(cnt_q < gexp_pkg::cnt_t'(gexp_pkg::STACK_DEPTH)) && !vis_rdata;

		unique case (state_q)
			gexp_pkg::ST_CLEAR: begin
				vis_we     = 1'b1;
				vis_waddr  = clr_addr_q;
				vis_wdata  = 1'b0;
				clr_addr_d = clr_addr_q + gexp_pkg::cell_t'(1);
				if (clr_addr_q == '1) begin
					state_d = gexp_pkg::ST_IDLE;
				end
			end
			gexp_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = gexp_pkg::ST_DECIDE;
				end
			end
			gexp_pkg::ST_DECIDE: begin
				// mark the current cell; fetch the stack top for a possible pop
				vis_we    = 1'b1;
				vis_wdata = 1'b1;
				stk_re    = 1'b1;
				if (chg_go) begin
					if (cnt_q == '0) begin
						if (out_free) begin
							fin        = 1'b1;
							res_chg    = 1'b1;
							chg_left_d = chl_dec;
							if (chl_dec == 8'd0) begin
								chg_flag_d = 1'b0;
								clr_addr_d = '0;
								state_d    = gexp_pkg::ST_CLEAR;
							end else begin
								chg_flag_d = 1'b1;
								state_d    = gexp_pkg::ST_IDLE;
							end
						end
					end else begin
						chg_flag_d = 1'b1;
						chg_left_d = chl;
						chg_path_d = 1'b1;
						state_d    = gexp_pkg::ST_POP;
					end
				end else if (dirt_q != 4'd0) begin
					if (out_free) begin
						fin     = 1'b1;
						state_d = gexp_pkg::ST_IDLE;
					end
				end else begin
					vis_re     = 1'b1;
					vis_raddr  = gexp_pkg::cell_of(
						gexp_pkg::step_x(pos_x_q, gexp_pkg::DIR_E),
						gexp_pkg::step_y(pos_y_q, gexp_pkg::DIR_E));
					probe_d_d  = gexp_pkg::DIR_E;
					chg_path_d = 1'b0;
					state_d    = gexp_pkg::ST_PROBE;
				end
			end
			gexp_pkg::ST_PROBE: begin
				if (ok) begin
					if (out_free) begin
						fin       = 1'b1;
						res_code  = gexp_pkg::move_of(pd);
						stk_we    = 1'b1;
						cnt_d     = cnt_q + gexp_pkg::cnt_t'(1);
						pos_x_d   = gexp_pkg::step_x(pos_x_q, pd);
						pos_y_d   = gexp_pkg::step_y(pos_y_q, pd);
						state_d   = gexp_pkg::ST_IDLE;
					end
				end else if (pd == gexp_pkg::DIR_N) begin
					state_d = gexp_pkg::ST_POP;
				end else begin
					// advance to the next direction in east, south, west, north order
					probe_d_d = gexp_pkg::next_dir(pd);
					vis_re    = 1'b1;
					vis_raddr = gexp_pkg::cell_of(
						gexp_pkg::step_x(pos_x_q, gexp_pkg::next_dir(pd)),
						gexp_pkg::step_y(pos_y_q, gexp_pkg::next_dir(pd)));
				end
			end
			gexp_pkg::ST_POP: begin
				if (out_free) begin
					fin     = 1'b1;
					res_chg = chg_path_q;
					state_d = gexp_pkg::ST_IDLE;
					if (cnt_q == '0) begin
						res_code = gexp_pkg::MV_FINISH;
					end else begin
						res_code = gexp_pkg::move_of(
							gexp_pkg::opp_dir(gexp_pkg::dir_t'(stk_rdata)));
						cnt_d    = cnt_q - gexp_pkg::cnt_t'(1);
						pos_x_d  = gexp_pkg::step_x(pos_x_q,
							gexp_pkg::opp_dir(gexp_pkg::dir_t'(stk_rdata)));
						pos_y_d  = gexp_pkg::step_y(pos_y_q,
							gexp_pkg::opp_dir(gexp_pkg::dir_t'(stk_rdata)));
					end
				end
			end
			default: begin
				state_d = gexp_pkg::ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			pos_x_q     <= '0;
			pos_y_q     <= '0;
			chg_flag_q  <= 1'b0;
			chg_left_q  <= 8'd0;
			chg_ticks_q <= 8'(gexp_pkg::CHARGE_RESET);
			chg_path_q  <= 1'b0;
			probe_d_q   <= gexp_pkg::DIR_E;
			clr_addr_q  <= '0;
			m_tvalid_q  <= 1'b0;
		end else begin
			cnt_q      <= cnt_d;
			pos_x_q    <= pos_x_d;
			pos_y_q    <= pos_y_d;
			chg_flag_q <= chg_flag_d;
			chg_left_q <= chg_left_d;
			chg_path_q <= chg_path_d;
			probe_d_q  <= probe_d_d;
			clr_addr_q <= clr_addr_d;
			if (cfg_we) begin
				chg_ticks_q <= cfg_data;
			end
			if (fin) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			dirt_q  <= s_tdata[3:0];
			batt_q  <= s_tdata[19:4];
			walls_q <= s_tdata[23:20];
		end
		if (fin) begin
			m_tdata_q <= {1'b0, gexp_pkg::off_t'(pos_y_d), gexp_pkg::off_t'(pos_x_d), res_code};
			m_tuser_q <= res_chg;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// an empty stack means every move has been retraced back to the dock
	`GEXP_ASSERT_NOW(a_dock_when_empty, cnt_q == '0,
		pos_x_q == '0 && pos_y_q == '0, "empty move stack away from dock")
	`GEXP_ASSERT_NOW(a_clear_not_charging, state_q == gexp_pkg::ST_CLEAR,
		!chg_flag_q && !s_tready, "map clear overlaps charging or input")
	`GEXP_ASSERT_NEXT(a_accept_to_decide, s_tvalid && s_tready,
		state_q == gexp_pkg::ST_DECIDE, "accepted beat not decided next cycle")

endmodule

FILE: dv/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int SETTLE_CYCLES  = 16;
	localparam int PHASE_ITEMS    = 320;

	typedef struct packed {
		gexp_pkg::move_t code;
		gexp_pkg::off_t  ox;
		gexp_pkg::off_t  oy;
		logic            chg;
	} move_result_t;

	// Tracks the explorer's walk and queues the move it must report for each tick.
	class move_tracker;
		bit [gexp_pkg::CELLS-1:0] visited;
		gexp_pkg::dir_t           trail [gexp_pkg::STACK_DEPTH];
		int unsigned              depth;
		gexp_pkg::pos_t           px, py;
		bit                       charging;
		logic [7:0]               charge_left;
		logic [7:0]               charge_ticks;
		move_result_t             pending_moves[$];
		int             errors, moves_checked, charge_runs, finishes, edge_blocks, max_depth;

		function new();
			visited      = '0;
			depth        = 0;
			px           = '0;
			py           = '0;
			charging     = 1'b0;
			charge_left  = '0;
			charge_ticks = 8'(gexp_pkg::CHARGE_RESET);
		endfunction

		function gexp_pkg::move_t move_for(gexp_pkg::dir_t d);
			case (d)
				gexp_pkg::DIR_N: return gexp_pkg::MV_NORTH;
				gexp_pkg::DIR_E: return gexp_pkg::MV_EAST;
				gexp_pkg::DIR_S: return gexp_pkg::MV_SOUTH;
				default:         return gexp_pkg::MV_WEST;
			endcase
		endfunction

		// pop the last step and walk it back
		function gexp_pkg::move_t retreat();
			gexp_pkg::dir_t d;
			if (depth == 0)
				return gexp_pkg::MV_FINISH;
			depth--;
			d = trail[depth];
			case (d)
				gexp_pkg::DIR_N: begin
					py = py + gexp_pkg::pos_t'(1);
					return gexp_pkg::MV_SOUTH;
				end
				gexp_pkg::DIR_E: begin
					px = px - gexp_pkg::pos_t'(1);
					return gexp_pkg::MV_WEST;
				end
				gexp_pkg::DIR_S: begin
					py = py - gexp_pkg::pos_t'(1);
					return gexp_pkg::MV_NORTH;
				end
				default: begin
					px = px + gexp_pkg::pos_t'(1);
					return gexp_pkg::MV_EAST;
				end
			endcase
		endfunction

		function void note_tick(logic [3:0] dirt, logic [15:0] battery, logic [3:0] walls);
			move_result_t   r;
			gexp_pkg::dir_t probe_order [4];
			gexp_pkg::dir_t d;
			int             nx, ny;
			bit             moved;
			probe_order = '{gexp_pkg::DIR_E, gexp_pkg::DIR_S, gexp_pkg::DIR_W,
				gexp_pkg::DIR_N};
			visited[gexp_pkg::cell_t'({px, py})] = 1'b1;
			r.chg = 1'b0;
			if (charging || battery <= depth) begin
				r.chg = 1'b1;
				if (!charging) begin
					charging    = 1'b1;
					charge_left = charge_ticks;
					charge_runs++;
				end
				if (depth == 0) begin
					// a zero setting wraps, so the charge lasts 256 ticks
					charge_left = charge_left - 8'd1;
					if (charge_left == 0) begin
						charging = 1'b0;
						visited  = '0;
					end
					r.code = gexp_pkg::MV_STAY;
				end else begin
					r.code = retreat();
				end
			end else if (dirt != 0) begin
				r.code = gexp_pkg::MV_STAY;
			end else begin
				moved = 1'b0;
				for (int k = 0; k < 4 && !moved; k++) begin
					d  = probe_order[k];
					nx = int'(px);
					ny = int'(py);
					case (d)
						gexp_pkg::DIR_N: ny--;
						gexp_pkg::DIR_E: nx++;
						gexp_pkg::DIR_S: ny++;
						default:         nx--;
					endcase
					if (nx < int'(gexp_pkg::POS_MIN) || nx > int'(gexp_pkg::POS_MAX) ||
							ny < int'(gexp_pkg::POS_MIN) ||
							ny > int'(gexp_pkg::POS_MAX)) begin
						edge_blocks++;
					end else if (!walls[d] && !visited[gexp_pkg::cell_t'(
							{gexp_pkg::pos_t'(nx), gexp_pkg::pos_t'(ny)})] &&
							depth < gexp_pkg::STACK_DEPTH) begin
						trail[depth] = d;
						depth++;
						px     = gexp_pkg::pos_t'(nx);
						py     = gexp_pkg::pos_t'(ny);
						r.code = move_for(d);
						moved  = 1'b1;
					end
				end
				if (!moved) begin
					r.code = retreat();
					if (r.code == gexp_pkg::MV_FINISH)
						finishes++;
				end
			end
			if (depth > max_depth)
				max_depth = depth;
			r.ox = px;
			r.oy = py;
			pending_moves = {pending_moves, r};
		endfunction

		function void check_move(move_result_t got);
			move_result_t want;
			if (pending_moves.size() == 0) begin
				$error("move beat with nothing pending: move_code %0d", got.code);
				errors++;
				return;
			end
			want = pending_moves.pop_front();
			moves_checked++;
			if (got.code !== want.code) begin
				$error("move_code: expected %0d, got %0d", want.code, got.code);
				errors++;
			end
			if (got.ox !== want.ox) begin
				$error("offset_x: expected %0d, got %0d", want.ox, got.ox);
				errors++;
			end
			if (got.oy !== want.oy) begin
				$error("offset_y: expected %0d, got %0d", want.oy, got.oy);
				errors++;
			end
			if (got.chg !== want.chg) begin
				$error("charging_now: expected %0d, got %0d", want.chg, got.chg);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;   // dirt_level, battery_steps, wall_bits
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;   // move_code, offset_x, offset_y, zero pad
	logic        m_tuser;   // charging_now
	logic        cfg_we;
	logic [7:0]  cfg_data;

	move_tracker    tracker;
	bit             no_idle;
	int             burst_left;
	gexp_pkg::dir_t burst_dir;
	int             stall_cycles;
	logic [7:0]     last_setting;

	grid_explorer_with_backtrack_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin : beat_monitor
		move_result_t got;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				tracker.note_tick(s_tdata[3:0], s_tdata[19:4], s_tdata[23:20]);
			if (m_tvalid && m_tready) begin
				got.code = gexp_pkg::move_t'(m_tdata[2:0]);
				got.ox   = m_tdata[8:3];
				got.oy   = m_tdata[14:9];
				got.chg  = m_tuser;
				tracker.check_move(got);
			end
		end
	end

	// the map clear after reset or a charge keeps s_tready low until every cell is cleared
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("grid_explorer_with_backtrack_core regression: fail");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// result side: random back-pressure per beat
	initial begin
		int n;
		m_tready = 1'b0;
		wait (arst_n);
		@(negedge clk);
		forever begin
			n = no_idle ? 0 : $urandom_range(0, 17);
			if (n > 0) begin
				m_tready <= 1'b0;
				repeat (n) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			@(negedge clk);
		end
	end

	// entered at a falling edge; leaves s_tvalid high after the beat is taken
	task automatic send_beat(input logic [23:0] beat);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tdata  <= beat;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic send_fields(input logic [3:0] dirt, input logic [15:0] battery,
			input logic [3:0] walls);
		send_beat({walls, battery, dirt});
	endtask

	// hold the input side until every pending move has come out
	task automatic settle();
		s_tvalid <= 1'b0;
		while (tracker.pending_moves.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_charge_ticks(input logic [7:0] ticks);
		cfg_data <= ticks;
		cfg_we   <= 1'b1;
		@(negedge clk);
		cfg_we   <= 1'b0;
		tracker.charge_ticks = ticks;
		last_setting         = ticks;
	endtask

	// mostly steered runs: walls close every direction tried ahead of the burst's heading
	task automatic make_beat(output logic [23:0] beat);
		gexp_pkg::dir_t probe_order [4];
		logic [3:0]     dirt, walls;
		logic [15:0]    battery;
		int             pick;
		probe_order = '{gexp_pkg::DIR_E, gexp_pkg::DIR_S, gexp_pkg::DIR_W, gexp_pkg::DIR_N};
		if (burst_left == 0) begin
			burst_dir  = gexp_pkg::dir_t'($urandom_range(0, 3));
			burst_left = $urandom_range(8, 60);
			no_idle    = ($urandom_range(0, 3) == 0);
		end
		burst_left--;
		if ($urandom_range(0, 99) < 8) begin
			beat = 24'($urandom);
			return;
		end
		dirt = ($urandom_range(0, 99) < 15) ? 4'($urandom_range(1, 15)) : 4'd0;
		for (int b = 0; b < 4; b++)
			walls[b] = ($urandom_range(0, 4) == 0);
		foreach (probe_order[k]) begin
			if (probe_order[k] == burst_dir)
				break;
			walls[probe_order[k]] = 1'b1;
		end
		walls[burst_dir] = 1'b0;
		// boxed in at the dock with an empty trail: finish
		if (tracker.depth == 0 && !tracker.charging && $urandom_range(0, 9) == 0)
			walls = 4'hF;
		pick = $urandom_range(0, 99);
		if (pick < 1)
			battery = 16'(tracker.depth);
		else if (pick < 2)
			battery = 16'($urandom_range(0, tracker.depth));
		else if (pick < 4)
			battery = 16'(tracker.depth + 1);
		else
			battery = 16'($urandom_range(4096, 65535));
		beat = {walls, battery, dirt};
	endtask

	initial begin
		logic [23:0] beat;
		logic [7:0]  settings [5];
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		cfg_we       = 1'b0;
		cfg_data     = '0;
		arst_n       = 1'b0;
		no_idle      = 1'b0;
		burst_left   = 0;
		burst_dir    = gexp_pkg::DIR_E;
		last_setting = 8'(gexp_pkg::CHARGE_RESET);
		tracker      = new();
		settings     = '{8'(gexp_pkg::CHARGE_RESET), 8'd1, 8'd255, 8'd0,
			8'($urandom_range(2, 254))};
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_fields(4'hF, 16'hFFFF, 4'h0);   // dirty: stay
		send_fields(4'h0, 16'hFFFF, 4'hF);   // boxed in at dock: finish
		send_fields(4'h0, 16'hFFFF, 4'h0);   // east first
		send_fields(4'h0, 16'hFFFF, 4'h2);   // east walled: south
		send_fields(4'h0, 16'hFFFF, 4'h6);   // east and south walled: west
		send_fields(4'h0, 16'hFFFF, 4'hE);   // north already visited: back east
		send_fields(4'h0, 16'hFFFF, 4'hF);   // all walled: back north
		send_fields(4'h0, 16'd2, 4'h0);      // battery one above trail: still explores
		send_fields(4'h0, 16'd2, 4'h0);      // battery equal to trail: head home
		send_fields(4'h7, 16'hFFFF, 4'h0);   // charging overrides dirt and battery
		send_fields(4'h0, 16'hFFFF, 4'h0);   // at dock: charge tick

		foreach (settings[p]) begin
			if (p > 0) begin
				settle();
				write_charge_ticks(settings[p]);
			end
			repeat (PHASE_ITEMS) begin
				make_beat(beat);
				send_beat(beat);
				if ($urandom_range(0, 199) == 0)
					settle();
			end
		end
		settle();

		$display("checked %0d moves under charge settings 20, 1, 255, 0 and %0d",
				tracker.moves_checked, last_setting);
		$display("%0d charge runs, %0d finishes, %0d edge-blocked probes, deepest trail %0d",
				tracker.charge_runs, tracker.finishes, tracker.edge_blocks, tracker.max_depth);
		if (tracker.errors == 0 && tracker.pending_moves.size() == 0)
			$display("grid_explorer_with_backtrack_core regression: pass");
		else
			$display("grid_explorer_with_backtrack_core regression: fail");
		$finish;
	end

endmodule

FILE: files.f
+incdir+rtl
rtl/gexp_pkg.sv
rtl/gexp_ram.sv
rtl/grid_explorer_with_backtrack_core.sv
dv/testbench.sv
